// ===== rtl/sawfr_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the file receiver.
package sawfr_pkg;

  localparam int CHUNK_MAX_DEF = 200;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_OFFER    = 3'd0,
    ACT_HEADER   = 3'd1,
    ACT_BYTE     = 3'd2,
    ACT_COMPLETE = 3'd3,
    ACT_ABORT    = 3'd4,
    ACT_ACCEPT   = 3'd5,
    ACT_REJECT   = 3'd6,
    ACT_RESTART  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    RP_NONE   = 3'd0,
    RP_ACCEPT = 3'd1,
    RP_REJECT = 3'd2,
    RP_ACK    = 3'd3,
    RP_ABORT  = 3'd4
  } reply_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  seq;
    logic [47:0] peer_addr;
    logic [31:0] offset;
    logic [31:0] total_size;
    logic [31:0] announced_crc;
    logic [7:0]  offered_chunk;
    logic [7:0]  hdr_len;
    logic [7:0]  payload_byte;
    logic        write_ok;
    logic        open_ok;
  } in_item_t;

  typedef struct packed {
    logic        handled;
    logic [2:0]  reply_kind;
    logic [7:0]  reply_seq;
    logic [47:0] reply_addr;
    logic [2:0]  status;
    logic [31:0] bytes_received;
    logic [7:0]  chunk_in_use;
    logic        close_sink;
  } out_item_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] r;
    r = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sawfr_in_stage.sv =====
// Input register stage: holds one transaction until the core takes it.
module sawfr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sawfr_pkg::in_item_t in_data,
  input  logic                adv,
  output logic                s1_valid,
  output sawfr_pkg::in_item_t s1_data
);
  import sawfr_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_data_r;
  logic     load;

  assign in_stall = s1_valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

// ===== rtl/sawfr_core.sv =====
// Receiver state, per-event update and the result register.
module sawfr_core #(
  parameter int CHUNK_MAX = sawfr_pkg::CHUNK_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  sawfr_pkg::in_item_t  s1_data,
  output logic                 adv,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sawfr_pkg::out_item_t out_data
);
  import sawfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OFFER = 3'd1,
    PH_RECV  = 3'd2,
    PH_DONE  = 3'd3,
    PH_FAIL  = 3'd4
  } phase_t;

  localparam logic [7:0] CHUNK_MAX_B = 8'(CHUNK_MAX);

  phase_t      phase_r, phase_nxt;
  logic [47:0] sender_addr_r, sender_addr_nxt;
  logic [31:0] expected_size_r, expected_size_nxt;
  logic [31:0] expected_crc_r, expected_crc_nxt;
  logic [7:0]  chunk_limit_r, chunk_limit_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        sink_open_r, sink_open_nxt;
  logic        chunk_active_r, chunk_active_nxt;
  logic [7:0]  chunk_left_r, chunk_left_nxt;
  logic [7:0]  chunk_seq_r, chunk_seq_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        go;
  logic        handled;
  reply_t      rkind;
  logic [7:0]  rseq;
  logic        close_req;
  logic [7:0]  left_dec;

  assign adv      = !out_valid_r || !out_stall;
  assign go       = s1_valid && adv;
  assign left_dec = chunk_left_r - 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    sender_addr_nxt   = sender_addr_r;
    expected_size_nxt = expected_size_r;
    expected_crc_nxt  = expected_crc_r;
    chunk_limit_nxt   = chunk_limit_r;
    byte_count_nxt    = byte_count_r;
    crc_nxt           = crc_r;
    sink_open_nxt     = sink_open_r;
    chunk_active_nxt  = chunk_active_r;
    chunk_left_nxt    = chunk_left_r;
    chunk_seq_nxt     = chunk_seq_r;
    handled           = 1'b0;
    rkind             = RP_NONE;
    rseq              = 8'd0;
    close_req         = 1'b0;
    case (s1_data.action)
      ACT_OFFER: begin
        if (phase_r == PH_IDLE) begin
          sender_addr_nxt   = s1_data.peer_addr;
          expected_size_nxt = s1_data.total_size;
          expected_crc_nxt  = s1_data.announced_crc;
          chunk_limit_nxt   = (s1_data.offered_chunk == 8'd0 ||
                               s1_data.offered_chunk > CHUNK_MAX_B) ?
                              CHUNK_MAX_B : s1_data.offered_chunk;
          phase_nxt         = PH_OFFER;
          handled           = 1'b1;
        end
      end
      ACT_HEADER: begin
        if (phase_r == PH_RECV) begin
          if (s1_data.offset != byte_count_r) begin
            chunk_active_nxt = 1'b0;
            chunk_left_nxt   = 8'd0;
          end else begin
            handled       = 1'b1;
            chunk_seq_nxt = s1_data.seq;
            if (s1_data.hdr_len == 8'd0) begin
              chunk_active_nxt = 1'b0;
              chunk_left_nxt   = 8'd0;
              rkind            = RP_ACK;
              rseq             = s1_data.seq;
            end else begin
              chunk_active_nxt = 1'b1;
              chunk_left_nxt   = s1_data.hdr_len;
            end
          end
        end
      end
      ACT_BYTE: begin
        if (phase_r == PH_RECV && chunk_active_r) begin
          handled = 1'b1;
          if (sink_open_r && !s1_data.write_ok) begin
            rkind            = RP_ABORT;
            rseq             = chunk_seq_r;
            phase_nxt        = PH_FAIL;
            chunk_active_nxt = 1'b0;
            chunk_left_nxt   = 8'd0;
          end else begin
            crc_nxt        = crc_fold(crc_r, s1_data.payload_byte);
            byte_count_nxt = byte_count_r + 32'd1;
            chunk_left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              chunk_active_nxt = 1'b0;
              rkind            = RP_ACK;
              rseq             = chunk_seq_r;
            end
          end
        end
      end
      ACT_COMPLETE: begin
        if (phase_r == PH_RECV) begin
          handled = 1'b1;
          if ((~crc_r) == expected_crc_r && byte_count_r == expected_size_r) begin
            phase_nxt = PH_DONE;
          end else begin
            rkind     = RP_ABORT;
            rseq      = s1_data.seq;
            phase_nxt = PH_FAIL;
          end
          close_req        = sink_open_r;
          sink_open_nxt    = 1'b0;
          chunk_active_nxt = 1'b0;
          chunk_left_nxt   = 8'd0;
        end
      end
      ACT_ABORT: begin
        handled          = 1'b1;
        phase_nxt        = PH_FAIL;
        close_req        = sink_open_r;
        sink_open_nxt    = 1'b0;
        chunk_active_nxt = 1'b0;
        chunk_left_nxt   = 8'd0;
      end
      ACT_ACCEPT: begin
        if (phase_r == PH_OFFER) begin
          if (!s1_data.open_ok) begin
            phase_nxt = PH_FAIL;
          end else begin
            handled          = 1'b1;
            sink_open_nxt    = 1'b1;
            rkind            = RP_ACCEPT;
            phase_nxt        = PH_RECV;
            byte_count_nxt   = 32'd0;
            crc_nxt          = CRC_INIT;
            chunk_active_nxt = 1'b0;
            chunk_left_nxt   = 8'd0;
          end
        end
      end
      ACT_REJECT: begin
        if (phase_r == PH_OFFER) begin
          handled   = 1'b1;
          rkind     = RP_REJECT;
          phase_nxt = PH_IDLE;
        end
      end
      ACT_RESTART: begin
        close_req         = sink_open_r;
        handled           = 1'b1;
        phase_nxt         = PH_IDLE;
        sender_addr_nxt   = 48'd0;
        expected_size_nxt = 32'd0;
        expected_crc_nxt  = 32'd0;
        chunk_limit_nxt   = 8'd0;
        byte_count_nxt    = 32'd0;
        crc_nxt           = CRC_INIT;
        sink_open_nxt     = 1'b0;
        chunk_active_nxt  = 1'b0;
        chunk_left_nxt    = 8'd0;
        chunk_seq_nxt     = 8'd0;
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.handled        = handled;
    out_data_nxt.reply_kind     = rkind;
    out_data_nxt.reply_seq      = rseq;
    out_data_nxt.reply_addr     = sender_addr_nxt;
    out_data_nxt.status         = phase_nxt;
    out_data_nxt.bytes_received = byte_count_nxt;
    out_data_nxt.chunk_in_use   = chunk_limit_nxt;
    out_data_nxt.close_sink     = close_req;
    out_valid_nxt = go ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      sender_addr_r   <= 48'd0;
      expected_size_r <= 32'd0;
      expected_crc_r  <= 32'd0;
      chunk_limit_r   <= 8'd0;
      byte_count_r    <= 32'd0;
      crc_r           <= CRC_INIT;
      sink_open_r     <= 1'b0;
      chunk_active_r  <= 1'b0;
      chunk_left_r    <= 8'd0;
      chunk_seq_r     <= 8'd0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        phase_r         <= phase_nxt;
        sender_addr_r   <= sender_addr_nxt;
        expected_size_r <= expected_size_nxt;
        expected_crc_r  <= expected_crc_nxt;
        chunk_limit_r   <= chunk_limit_nxt;
        byte_count_r    <= byte_count_nxt;
        crc_r           <= crc_nxt;
        sink_open_r     <= sink_open_nxt;
        chunk_active_r  <= chunk_active_nxt;
        chunk_left_r    <= chunk_left_nxt;
        chunk_seq_r     <= chunk_seq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_chunk_in_recv: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_active_r |-> phase_r == PH_RECV)
    else $error("chunk armed outside receiving phase");

  a_chunk_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_active_r |-> chunk_left_r != 8'd0)
    else $error("armed chunk has no bytes left");

  a_sink_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sink_open_r |-> (phase_r == PH_RECV || phase_r == PH_FAIL))
    else $error("sink open in unexpected phase");

  a_reply_handled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.reply_kind != RP_NONE) |-> out_data_r.handled)
    else $error("reply issued for unhandled event");

endmodule

// ===== rtl/stop_and_wait_file_receiver_unit.sv =====
// Top level of the stop-and-wait file receiver.
// Usage:
//   in_valid/in_stall/in_data carry one event transaction (offer, data header,
//   data byte, complete, abort, accept, reject, restart).
//   out_valid/out_stall/out_data carry exactly one result transaction per
//   event: handled flag, reply to send, status, byte count, chunk size in use
//   and a close-sink request.
//   A transaction moves on a rising edge with valid high and stall low.
//   An accepted event goes through the input register, then the result register,
//   before its result is valid. Throughput: one event per cycle while out_stall is low; the
//   byte-wide CRC-32 update is a single combinational fold between the two registers.
//   When out_stall is held, the result register keeps its transaction, the
//   input register fills, and in_stall rises; no transaction is lost.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   receiver to idle with a zero byte count and the CRC register at all ones.
module stop_and_wait_file_receiver_unit #(
  parameter int CHUNK_MAX = sawfr_pkg::CHUNK_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sawfr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sawfr_pkg::out_item_t out_data
);
  import sawfr_pkg::*;

  logic     adv;
  logic     s1_valid;
  in_item_t s1_data;

  sawfr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  sawfr_core #(
    .CHUNK_MAX (CHUNK_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
